### rtl/mmt_pkg.sv
// ----------------------------------------------------------------------------
// mmt_pkg - shared types and constants of the matrix multiply engine
// Item and result structs, register indexes, mode and form codes, FSM states.
// ----------------------------------------------------------------------------
package mmt_pkg;

  localparam int unsigned MAX_DIM     = 8;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ACC_W       = 56;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned REG_IDX_W   = 3;

  localparam logic [REG_IDX_W-1:0] REG_ROWS_A       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS_A       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROWS_B       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PRODUCT_FORM = 3'd4;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;

  localparam logic [1:0] FORM_AB  = 2'd0;
  localparam logic [1:0] FORM_TAB = 2'd1;
  localparam logic [1:0] FORM_ATB = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic [ADDR_W-1:0]        elem_index;
    logic signed [DATA_W-1:0] elem_value;
  } mmt_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prod_value;
    logic [ADDR_W-1:0]        out_index;
    logic                     last;
    logic                     dim_error;
  } mmt_out_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic fin;
  } mmt_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } mmt_state_t;

endpackage

### rtl/matrix_multiply_transpose_modes.sv
// ----------------------------------------------------------------------------
// matrix_multiply_transpose_modes - Q16.16 matrix multiply with transpose forms
// Loads fill the A and B stores; a start walks the product through one shared
// multiply-accumulate datapath and emits every element in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A load (mode load A
//   or load B) writes one element in that cycle and gives no result; busy stays
//   low, so loads may follow every cycle.
//   A start raises busy and issues one multiply-accumulate step per cycle, one
//   step per inner index k, through a four-deep pipeline: store read, 32x32
//   multiply, accumulate, saturate. Busy then stays high until the pipeline
//   has drained.
//   A dimension error gives a single result with dim_error and last set in the
//   cycle after the start; busy stays low.
//   Each result is on result for exactly one cycle with valid high; the
//   receiver cannot stall, so nothing is held back.
//   Configuration is written through wr_en, wr_index and wr_data; the user must
//   do so only while idle, as the block does not enforce it. A synchronous
//   reset sets every dimension to 1 and the form to A*B and clears the
//   sequencer and valid; store contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module matrix_multiply_transpose_modes
  import mmt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  mmt_in_t              item,
  output logic                 valid,
  output mmt_out_t             result,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [DIM_W-1:0]     wr_data
);

  localparam logic signed [ACC_W-1:0] SAT_MAX = 56'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -56'sd2147483648;

  logic [DIM_W-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [1:0]       product_form;

  mmt_state_t state, state_next;

  logic [DIM_W-1:0] nr, nc, inner;
  logic [DIM_W-1:0] ci, cj, ck;
  logic [ADDR_W-1:0] n_cnt;

  logic accept, start_go, start_err, issue, step_fin;
  logic k_end, j_end, i_end;

  logic [DIM_W-1:0] nr_sel, nc_sel, inner_sel;
  logic             form_err;
  logic             dims_err;

  logic [DIM_W-1:0]  ma, na, mb, nb;
  logic [7:0]        ia_full, ib_full;
  logic [ADDR_W-1:0] addr_a, addr_b;

  logic signed [DATA_W-1:0] store_a [STORE_DEPTH];
  logic signed [DATA_W-1:0] store_b [STORE_DEPTH];
  logic signed [DATA_W-1:0] rd_a, rd_b;

  logic signed [2*DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] term_full;
  logic signed [ACC_W-1:0]    term, acc, acc_sum;

  mmt_tag_t tag1, tag2, tag3;

  function automatic logic dim_bad(input logic [DIM_W-1:0] d);
    return (d == '0) || (32'(d) > MAX_DIM);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a       <= DIM_W'(1);
      cols_a       <= DIM_W'(1);
      rows_b       <= DIM_W'(1);
      cols_b       <= DIM_W'(1);
      product_form <= FORM_AB;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROWS_A:       rows_a       <= wr_data;
        REG_COLS_A:       cols_a       <= wr_data;
        REG_ROWS_B:       rows_b       <= wr_data;
        REG_COLS_B:       cols_b       <= wr_data;
        REG_PRODUCT_FORM: product_form <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    form_err  = 1'b0;
    nr_sel    = rows_a;
    nc_sel    = cols_b;
    inner_sel = cols_a;
    case (product_form)
      FORM_AB: begin
        form_err  = (cols_a != rows_b);
        nr_sel    = rows_a;
        nc_sel    = cols_b;
        inner_sel = cols_a;
      end
      FORM_TAB: begin
        form_err  = (rows_a != rows_b);
        nr_sel    = cols_a;
        nc_sel    = cols_b;
        inner_sel = rows_a;
      end
      FORM_ATB: begin
        form_err  = (cols_a != cols_b);
        nr_sel    = rows_a;
        nc_sel    = rows_b;
        inner_sel = cols_a;
      end
      default: form_err = 1'b1;
    endcase
  end

  always_comb begin
    dims_err = dim_bad(rows_a) || dim_bad(cols_a) || dim_bad(rows_b) || dim_bad(cols_b)
            || ((8'(rows_a) * 8'(cols_a)) > 8'(STORE_DEPTH))
            || ((8'(rows_b) * 8'(cols_b)) > 8'(STORE_DEPTH))
            || ((8'(nr_sel) * 8'(nc_sel)) > 8'(STORE_DEPTH));
  end

  assign accept    = start && !busy;
  assign start_err = accept && (item.mode == MODE_START) && (dims_err || form_err);
  assign start_go  = accept && (item.mode == MODE_START) && !(dims_err || form_err);

  assign k_end    = (ck == inner - DIM_W'(1));
  assign j_end    = (cj == nc - DIM_W'(1));
  assign i_end    = (ci == nr - DIM_W'(1));
  assign step_fin = k_end && j_end && i_end;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start_go) state_next = ST_RUN;
      ST_RUN:   if (step_fin) state_next = ST_DRAIN;
      ST_DRAIN: if (!tag1.valid && !tag2.valid && !tag3.valid) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    case (state)
      ST_IDLE:  busy = 1'b0;
      ST_RUN:   issue = 1'b1;
      ST_DRAIN: busy = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start_go) begin
      nr    <= nr_sel;
      nc    <= nc_sel;
      inner <= inner_sel;
      ci    <= '0;
      cj    <= '0;
      ck    <= '0;
    end else if (issue) begin
      if (k_end) begin
        ck <= '0;
        if (j_end) begin
          cj <= '0;
          ci <= ci + DIM_W'(1);
        end else begin
          cj <= cj + DIM_W'(1);
        end
      end else begin
        ck <= ck + DIM_W'(1);
      end
    end
  end

  always_comb begin
    ma = (product_form == FORM_TAB) ? ck : ci;
    na = (product_form == FORM_TAB) ? ci : ck;
    mb = (product_form == FORM_ATB) ? cj : ck;
    nb = (product_form == FORM_ATB) ? ck : cj;
    ia_full = 8'(ma) * 8'(cols_a) + 8'(na);
    ib_full = 8'(mb) * 8'(cols_b) + 8'(nb);
    addr_a  = ia_full[ADDR_W-1:0];
    addr_b  = ib_full[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept && (item.mode == MODE_LOAD_A)) begin
      store_a[item.elem_index] <= item.elem_value;
    end
    rd_a <= store_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (accept && (item.mode == MODE_LOAD_B)) begin
      store_b[item.elem_index] <= item.elem_value;
    end
    rd_b <= store_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
    end else begin
      tag1.valid <= issue;
      tag1.first <= (ck == '0);
      tag1.last  <= k_end;
      tag1.fin   <= step_fin;
      tag2       <= tag1;
      tag3       <= tag2;
    end
  end

  assign term_full = prod >>> FRAC_W;
  assign term      = term_full[ACC_W-1:0];
  assign acc_sum   = acc + term;

  always_ff @(posedge clk) begin
    prod <= rd_a * rd_b;
    if (tag2.valid) begin
      acc <= tag2.first ? term : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= start_err || (tag3.valid && tag3.last);
    end
  end

  always_ff @(posedge clk) begin
    if (start_go) begin
      n_cnt <= '0;
    end else if (tag3.valid && tag3.last) begin
      n_cnt <= n_cnt + ADDR_W'(1);
    end
    if (start_err) begin
      result.prod_value <= '0;
      result.out_index  <= '0;
      result.last       <= 1'b1;
      result.dim_error  <= 1'b1;
    end else if (tag3.valid && tag3.last) begin
      if (acc > SAT_MAX) begin
        result.prod_value <= SAT_MAX[DATA_W-1:0];
      end else if (acc < SAT_MIN) begin
        result.prod_value <= SAT_MIN[DATA_W-1:0];
      end else begin
        result.prod_value <= acc[DATA_W-1:0];
      end
      result.out_index <= n_cnt;
      result.last      <= tag3.fin;
      result.dim_error <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !(tag1.valid || tag2.valid || tag3.valid))
    else $error("pipeline not empty while idle");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (valid && result.dim_error) |-> result.last)
    else $error("error result without last");

  a_issue_from_run: assert property (@(posedge clk) disable iff (rst)
    tag1.valid |-> $past(state == ST_RUN))
    else $error("step issued outside run");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start_go |=> (state == ST_RUN))
    else $error("valid start did not enter run");

  a_error_no_run: assert property (@(posedge clk) disable iff (rst)
    start_err |=> (valid && result.dim_error && (state == ST_IDLE)))
    else $error("error start did not give one error result");
`endif

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb - regression bench for the Q16.16 matrix multiply engine
// A short scripted run covers saturation, floor rounding of negative terms,
// ignored items, the store edges and every kind of dimension fault. Random
// phases follow, each with its own shape and product form. Each phase loads
// operands and launches products, with stray loads and ignored items mixed in.
// Every result is checked, against scripted values or an in-bench model of the engine.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mmt_pkg::*;

  localparam int unsigned RAND_ITEMS   = 250;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned QUIET_CYCLES = 8;
  localparam logic [1:0]  MODE_NONE    = 2'd3;
  localparam logic [1:0]  FORM_NONE    = 2'd3;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;
  localparam mmt_out_t DIM_FAULT = '{prod_value: '0, out_index: '0, last: 1'b1,
                                     dim_error: 1'b1};

  typedef struct {
    bit                   is_cfg;
    logic [1:0]           mode;
    logic [REG_IDX_W-1:0] sel;
    logic [ADDR_W-1:0]    idx;
    logic [DATA_W-1:0]    value;
    bit                   typed;
    mmt_out_t             want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  mmt_in_t              item;
  logic                 valid;
  mmt_out_t             result;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [DIM_W-1:0]     wr_data;
  logic                 typed_on;
  mmt_out_t             typed_want;

  logic signed [DATA_W-1:0] mat_a [STORE_DEPTH];
  logic signed [DATA_W-1:0] mat_b [STORE_DEPTH];
  bit                       seen_a [STORE_DEPTH];
  bit                       seen_b [STORE_DEPTH];
  logic [DIM_W-1:0]         cfg_rows_a = 4'd1;
  logic [DIM_W-1:0]         cfg_cols_a = 4'd1;
  logic [DIM_W-1:0]         cfg_rows_b = 4'd1;
  logic [DIM_W-1:0]         cfg_cols_b = 4'd1;
  logic [1:0]               cfg_form   = FORM_AB;

  mmt_out_t pending_elems [$];
  int       mismatches = 0;
  int       sent = 0;
  int       cycles = 0;

  matrix_multiply_transpose_modes i_dut (
    .clk,
    .rst,
    .start,
    .busy,
    .item,
    .valid,
    .result,
    .wr_en,
    .wr_index,
    .wr_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic script_row_t ld(logic [1:0] m, logic [ADDR_W-1:0] i,
                                     logic [DATA_W-1:0] v);
    return '{1'b0, m, '0, i, v, 1'b0, '0};
  endfunction

  function automatic script_row_t go(bit chk, mmt_out_t w);
    return '{1'b0, MODE_START, '0, '0, '0, chk, w};
  endfunction

  function automatic script_row_t cfg(logic [REG_IDX_W-1:0] r, logic [DIM_W-1:0] d);
    return '{1'b1, MODE_NONE, r, '0, DATA_W'(d), 1'b0, '0};
  endfunction

  function automatic mmt_out_t single(logic [DATA_W-1:0] v);
    return '{prod_value: v, out_index: '0, last: 1'b1, dim_error: 1'b0};
  endfunction

  function automatic logic [DATA_W-1:0] rand_q16();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2: return $urandom;
      default: return 32'($urandom_range(32'h10_0000)) - 32'h8_0000;
    endcase
  endfunction

  function automatic logic signed [63:0] q16_term(logic signed [DATA_W-1:0] a,
                                                  logic signed [DATA_W-1:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> FRAC_W;
  endfunction

  function automatic bit gemm_shape(output int nr, output int nc, output int inner);
    int ra, ca, rb, cb;
    ra = cfg_rows_a;
    ca = cfg_cols_a;
    rb = cfg_rows_b;
    cb = cfg_cols_b;
    nr = 0;
    nc = 0;
    inner = 0;
    if (ra < 1 || ra > MAX_DIM || ca < 1 || ca > MAX_DIM) return 1'b0;
    if (rb < 1 || rb > MAX_DIM || cb < 1 || cb > MAX_DIM) return 1'b0;
    if (ra * ca > STORE_DEPTH || rb * cb > STORE_DEPTH) return 1'b0;
    case (cfg_form)
      FORM_AB: begin
        if (ca != rb) return 1'b0;
        nr = ra; nc = cb; inner = ca;
      end
      FORM_TAB: begin
        if (ra != rb) return 1'b0;
        nr = ca; nc = cb; inner = ra;
      end
      FORM_ATB: begin
        if (ca != cb) return 1'b0;
        nr = ra; nc = rb; inner = ca;
      end
      default: return 1'b0;
    endcase
    return nr * nc <= STORE_DEPTH;
  endfunction

  task automatic predict_gemm();
    int nr, nc, inner, i, j, k, ia, ib, n, ca, cb;
    logic signed [63:0] acc;
    mmt_out_t elem;
    if (!gemm_shape(nr, nc, inner)) begin
      pending_elems.push_back(DIM_FAULT);
      return;
    end
    ca = cfg_cols_a;
    cb = cfg_cols_b;
    n = 0;
    for (i = 0; i < nr; i++) begin
      for (j = 0; j < nc; j++) begin
        acc = '0;
        for (k = 0; k < inner; k++) begin
          case (cfg_form)
            FORM_AB: begin ia = i * ca + k; ib = k * cb + j; end
            FORM_TAB: begin ia = k * ca + i; ib = k * cb + j; end
            default: begin ia = i * ca + k; ib = j * cb + k; end
          endcase
          acc += q16_term(mat_a[ia % STORE_DEPTH], mat_b[ib % STORE_DEPTH]);
        end
        if (acc > SAT_HI) acc = SAT_HI;
        if (acc < SAT_LO) acc = SAT_LO;
        elem.prod_value = acc[DATA_W-1:0];
        elem.out_index  = ADDR_W'(n);
        elem.last       = (n == nr * nc - 1);
        elem.dim_error  = 1'b0;
        pending_elems.push_back(elem);
        n++;
      end
    end
  endtask

  task automatic report(string what, mmt_out_t want, mmt_out_t got);
    if (mismatches < 10)
      $display("%s: expected value %h index %0d last %b err %b, got value %h index %0d last %b err %b",
               what, want.prod_value, want.out_index, want.last, want.dim_error,
               got.prod_value, got.out_index, got.last, got.dim_error);
    mismatches++;
  endtask

  task automatic check_result();
    mmt_out_t want;
    if (pending_elems.size() == 0) begin
      report("unexpected transaction", '0, result);
    end else begin
      want = pending_elems.pop_front();
      if (result.prod_value !== want.prod_value || result.out_index !== want.out_index ||
          result.last !== want.last || result.dim_error !== want.dim_error)
        report("field mismatch", want, result);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (valid) check_result();
      if (start && !busy) begin
        case (item.mode)
          MODE_LOAD_A: mat_a[item.elem_index] = item.elem_value;
          MODE_LOAD_B: mat_b[item.elem_index] = item.elem_value;
          MODE_START: begin
            if (typed_on) pending_elems.push_back(typed_want);
            else predict_gemm();
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("matrix_multiply_transpose_modes regression: fail");
      $finish;
    end
  end

  task automatic send(logic [1:0] m, logic [ADDR_W-1:0] i, logic [DATA_W-1:0] v,
                      bit chk, mmt_out_t w);
    bit steady;
    steady = sent >= 150 && sent < 210;
    if (!steady && $urandom_range(99) < 17) begin
      start <= 1'b0;
      wr_en <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start      <= 1'b1;
    wr_en      <= 1'b0;
    item       <= '{mode: m, elem_index: i, elem_value: v};
    typed_on   <= chk;
    typed_want <= w;
    do @(posedge clk); while (busy);
    if (m == MODE_LOAD_A) seen_a[i] = 1'b1;
    if (m == MODE_LOAD_B) seen_b[i] = 1'b1;
    if (m != MODE_NONE) sent++;
  endtask

  task automatic settle();
    int quiet;
    start <= 1'b0;
    wr_en <= 1'b0;
    quiet = 0;
    while (quiet < QUIET_CYCLES) begin
      @(negedge clk);
      quiet = (pending_elems.size() == 0 && !busy) ? quiet + 1 : 0;
    end
    @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
    case (idx)
      REG_ROWS_A:       cfg_rows_a = d;
      REG_COLS_A:       cfg_cols_a = d;
      REG_ROWS_B:       cfg_rows_b = d;
      REG_COLS_B:       cfg_cols_b = d;
      REG_PRODUCT_FORM: cfg_form   = d[1:0];
      default: ;
    endcase
  endtask

  task automatic refresh(logic [1:0] m, int count, bit partial);
    int i, n;
    if (count == 0) return;
    if (!partial && count <= 16) begin
      for (i = 0; i < count; i++) send(m, ADDR_W'(i), rand_q16(), 1'b0, '0);
    end else begin
      n = $urandom_range(1, (count < 12) ? count : 12);
      repeat (n) send(m, ADDR_W'($urandom_range(count - 1)), rand_q16(), 1'b0, '0);
    end
  endtask

  // load any operand entry the product would read before it was ever written, then start the product
  task automatic launch();
    int nr, nc, inner, i;
    if (gemm_shape(nr, nc, inner)) begin
      for (i = 0; i < int'(cfg_rows_a) * int'(cfg_cols_a); i++)
        if (!seen_a[i]) send(MODE_LOAD_A, ADDR_W'(i), rand_q16(), 1'b0, '0);
      for (i = 0; i < int'(cfg_rows_b) * int'(cfg_cols_b); i++)
        if (!seen_b[i]) send(MODE_LOAD_B, ADDR_W'(i), rand_q16(), 1'b0, '0);
    end
    send(MODE_START, ADDR_W'($urandom), $urandom, 1'b0, '0);
  endtask

  initial begin
    script_row_t script [$];
    bit          prev_cfg;
    int          phase, ra, ca, rb, cb, na, nb, pick;
    logic [1:0]  form;

    rst        <= 1'b1;
    start      <= 1'b0;
    item       <= '0;
    wr_en      <= 1'b0;
    wr_index   <= '0;
    wr_data    <= '0;
    typed_on   <= 1'b0;
    typed_want <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    script = '{
      ld(MODE_LOAD_A, 6'd0, 32'h7FFF_FFFF), ld(MODE_LOAD_B, 6'd0, 32'h7FFF_FFFF),
      go(1'b1, single(32'h7FFF_FFFF)),
      ld(MODE_LOAD_A, 6'd0, 32'h8000_0000), ld(MODE_LOAD_B, 6'd0, 32'h8000_0000),
      go(1'b1, single(32'h7FFF_FFFF)),
      ld(MODE_LOAD_B, 6'd0, 32'h7FFF_FFFF),
      go(1'b1, single(32'h8000_0000)),
      ld(MODE_LOAD_A, 6'd0, 32'h0001_0000), ld(MODE_LOAD_B, 6'd0, 32'hFFFF_FFFF),
      go(1'b1, single(32'hFFFF_FFFF)),
      ld(MODE_LOAD_A, 6'd0, 32'h0000_0001),
      go(1'b1, single(32'hFFFF_FFFF)),
      ld(MODE_NONE, 6'd63, 32'hFFFF_FFFF),
      ld(MODE_LOAD_A, 6'd63, 32'h5A5A_5A5A), ld(MODE_LOAD_B, 6'd63, 32'hA5A5_A5A5),
      go(1'b0, '0),
      cfg(REG_PRODUCT_FORM, 4'(FORM_NONE)),
      go(1'b1, DIM_FAULT),
      cfg(REG_PRODUCT_FORM, 4'(FORM_AB)), cfg(REG_ROWS_A, 4'd0),
      go(1'b1, DIM_FAULT),
      cfg(REG_ROWS_A, 4'd15),
      go(1'b1, DIM_FAULT),
      cfg(REG_ROWS_A, 4'd1), cfg(REG_COLS_A, 4'd2),
      go(1'b1, DIM_FAULT),
      cfg(REG_PRODUCT_FORM, 4'(FORM_ATB)),
      go(1'b1, DIM_FAULT),
      cfg(REG_COLS_A, 4'd1), cfg(REG_PRODUCT_FORM, 4'(FORM_TAB)),
      go(1'b0, '0),
      cfg(REG_PRODUCT_FORM, 4'(FORM_ATB)),
      go(1'b0, '0)
    };

    prev_cfg = 1'b0;
    foreach (script[s]) begin
      if (script[s].is_cfg) begin
        if (!prev_cfg) settle();
        write_reg(script[s].sel, script[s].value[DIM_W-1:0]);
      end else begin
        send(script[s].mode, script[s].idx, script[s].value, script[s].typed,
             script[s].want);
      end
      prev_cfg = script[s].is_cfg;
    end

    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      if (phase < 3) begin
        ra = MAX_DIM; ca = MAX_DIM; rb = MAX_DIM; cb = MAX_DIM;
        form = 2'(phase);
      end else begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          ra = $urandom_range(5, 8); ca = $urandom_range(5, 8);
          rb = $urandom_range(5, 8); cb = $urandom_range(5, 8);
        end else begin
          ra = $urandom_range(1, 4); ca = $urandom_range(1, 4);
          rb = $urandom_range(1, 4); cb = $urandom_range(1, 4);
        end
        form = 2'($urandom_range(2));
        if ($urandom_range(99) < 85) begin
          case (form)
            FORM_AB:  rb = ca;
            FORM_TAB: rb = ra;
            default:  cb = ca;
          endcase
        end
        if ($urandom_range(99) < 8) begin
          case ($urandom_range(4))
            0: ra = $urandom_range(1) ? 0 : $urandom_range(9, 15);
            1: ca = $urandom_range(1) ? 0 : $urandom_range(9, 15);
            2: rb = $urandom_range(1) ? 0 : $urandom_range(9, 15);
            3: cb = $urandom_range(1) ? 0 : $urandom_range(9, 15);
            default: form = FORM_NONE;
          endcase
        end
      end

      settle();
      write_reg(REG_ROWS_A, 4'(ra));
      write_reg(REG_COLS_A, 4'(ca));
      write_reg(REG_ROWS_B, 4'(rb));
      write_reg(REG_COLS_B, 4'(cb));
      write_reg(REG_PRODUCT_FORM, 4'(form));

      na = (ra * ca > STORE_DEPTH) ? STORE_DEPTH : ra * ca;
      nb = (rb * cb > STORE_DEPTH) ? STORE_DEPTH : rb * cb;
      refresh(MODE_LOAD_A, na, 1'b0);
      refresh(MODE_LOAD_B, nb, 1'b0);
      launch();
      if ($urandom_range(1)) begin
        refresh($urandom_range(1) ? MODE_LOAD_A : MODE_LOAD_B,
                $urandom_range(1) ? na : nb, 1'b1);
        launch();
      end
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(3))
          0: send(MODE_LOAD_A, ADDR_W'($urandom), rand_q16(), 1'b0, '0);
          1: send(MODE_LOAD_B, ADDR_W'($urandom), rand_q16(), 1'b0, '0);
          2: send(MODE_NONE, ADDR_W'($urandom), $urandom, 1'b0, '0);
          default: launch();
        endcase
      end
      phase++;
    end

    settle();
    if (mismatches == 0)
      $display("matrix_multiply_transpose_modes regression: pass");
    else
      $display("matrix_multiply_transpose_modes regression: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/mmt_pkg.sv
rtl/matrix_multiply_transpose_modes.sv
test/tb.sv
